// File: hw/rtl/mep_pkg.sv
// Shared types, constants and helpers of the Mandelbrot escape-time pixel block.
package mep_pkg;

    localparam int PIX_W      = 12;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_W     = 16;
    localparam int HUE_COUNT  = 6;
    localparam int HUE_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    // |z|^2 escape bound, 4.0 in Q8.56
    localparam logic [63:0] MAG_LIMIT = 64'h0400_0000_0000_0000;

    localparam logic [23:0] HUE_TABLE [HUE_COUNT] = '{
        24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'hFF00FF
    };

    // register word index, paddr[4:2]
    typedef enum logic [2:0] {
        REG_REAL_MIN  = 3'd0,
        REG_REAL_STEP = 3'd1,
        REG_IMAG_TOP  = 3'd2,
        REG_IMAG_STEP = 3'd3,
        REG_MAX_ITERS = 3'd4
    } t_reg;

    typedef struct packed {
        logic signed [31:0] real_min;
        logic [30:0]        real_step;
        logic signed [31:0] imag_top;
        logic [30:0]        imag_step;
        logic [ITER_W-1:0]  max_iters;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } t_cpt;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] == {17{v[47]}}) begin
            r = v[31:0];
        end else if (v[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mep_front.sv
// Front end: accept a pixel transfer and map it to the complex point c.
module mep_front import mep_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel_x,
    input  logic [PIX_W-1:0] i_pixel_y,
    output logic             o_valid,
    input  logic             i_ready,
    output t_cpt             o_c
);

    localparam int CB = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
    localparam logic [PIX_W-1:0] CMASK = PIX_W'((1 << CB) - 1);
    localparam int PW = PIX_W + 31;

    logic          r_v;
    logic [PW-1:0] r_px_prod;
    logic [PW-1:0] r_py_prod;
    logic          w_take;

    assign o_ready = !r_v || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_px_prod <= (i_pixel_x & CMASK) * i_cfg.real_step;
            r_py_prod <= (i_pixel_y & CMASK) * i_cfg.imag_step;
        end
    end

    // offset from the image edges, then clamp to Q4.28
    assign o_c.cr = sat32({{16{i_cfg.real_min[31]}}, i_cfg.real_min}
                          + {{(48-PW){1'b0}}, r_px_prod});
    assign o_c.ci = sat32({{16{i_cfg.imag_top[31]}}, i_cfg.imag_top}
                          - {{(48-PW){1'b0}}, r_py_prod});

endmodule

// File: hw/rtl/mep_queue.sv
// Short queue of mapped points between the front end and the iteration engine.
module mep_queue import mep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cpt i_c,
    output logic o_valid,
    input  logic i_ready,
    output t_cpt o_c
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cpt          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = r_cnt != CW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_c     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_c;
        end
    end

endmodule

// File: hw/rtl/mep_iter.sv
// Iteration engine: z <- z^2 + c loop, escape test, palette and result register.
module mep_iter import mep_pkg::*; #(
    parameter int SHADES_PER_HUE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cpt              i_c,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [23:0]       o_pixel_color,
    output logic              o_inside_set,
    output logic [ITER_W-1:0] o_escape_index
);

    localparam int SW = (SHADES_PER_HUE > 1) ? $clog2(SHADES_PER_HUE) : 1;
    localparam int RW = $clog2(SHADES_PER_HUE + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;

    logic [1:0]         r_state;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [63:0] r_sr;
    logic signed [63:0] r_si;
    logic signed [63:0] r_pp;
    logic [ITER_W-1:0]  r_cnt;
    logic [SW-1:0]      r_shade;
    logic [HUE_W-1:0]   r_hue;
    logic [SW-1:0]      r_lshade;
    logic [HUE_W-1:0]   r_lhue;
    logic               r_ovalid;
    logic [23:0]        r_color;
    logic               r_inside;
    logic [ITER_W-1:0]  r_index;

    logic signed [63:0] w_dr;
    logic signed [63:0] w_dp;
    logic signed [31:0] w_nr;
    logic signed [31:0] w_ni;
    logic [63:0]        w_mag;
    logic               w_esc;
    logic               w_done;
    logic               w_emit;
    logic [HUE_W-1:0]   w_nhue;
    logic [23:0]        w_color;
    logic [7:0]         w_ramp [SHADES_PER_HUE+1];

    for (genvar k = 0; k <= SHADES_PER_HUE; k++) begin : g_ramp
        localparam int RampVal = (255 * k) / SHADES_PER_HUE;
        assign w_ramp[k] = 8'(RampVal);
    end

    assign w_dr  = (r_sr - r_si) >>> FRAC_BITS;
    assign w_dp  = r_pp >>> (FRAC_BITS - 1);
    assign w_nr  = sat32(w_dr[47:0] + {{16{r_cr[31]}}, r_cr});
    assign w_ni  = sat32(w_dp[47:0] + {{16{r_ci[31]}}, r_ci});
    assign w_mag = r_sr + r_si;

    // squares in r_sr/r_si belong to the z left by the last step
    assign w_esc  = (r_cnt != '0) && (w_mag > MAG_LIMIT);
    assign w_done = w_esc || (r_cnt == i_cfg.max_iters);
    assign w_emit = (r_state == ST_ADD) && w_done && (!r_ovalid || i_ready);

    assign o_ready = r_state == ST_IDLE;

    assign w_nhue = (r_lhue == HUE_W'(HUE_COUNT - 1)) ? '0 : r_lhue + 1'b1;

    always_comb begin
        logic a0;
        logic a1;
        w_color = '0;
        for (int b = 0; b < 3; b++) begin
            a0 = HUE_TABLE[r_lhue][8*b+7];
            a1 = HUE_TABLE[w_nhue][8*b+7];
            if (a0 && a1) begin
                w_color[8*b +: 8] = 8'hFF;
            end else if (a0) begin
                w_color[8*b +: 8] = w_ramp[RW'(SHADES_PER_HUE) - RW'(r_lshade)];
            end else if (a1) begin
                w_color[8*b +: 8] = w_ramp[RW'(r_lshade)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (!w_done) begin
                        r_state <= ST_MUL;
                    end else if (w_emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cr    <= i_c.cr;
                r_ci    <= i_c.ci;
                r_zr    <= '0;
                r_zi    <= '0;
                r_cnt   <= '0;
                r_shade <= '0;
                r_hue   <= '0;
            end
            ST_MUL: begin
                r_sr <= r_zr * r_zr;
                r_si <= r_zi * r_zi;
                r_pp <= r_zr * r_zi;
            end
            ST_ADD: begin
                if (!w_done) begin
                    r_zr     <= w_nr;
                    r_zi     <= w_ni;
                    r_cnt    <= r_cnt + 1'b1;
                    // remember the palette slot of this step, then advance
                    r_lshade <= r_shade;
                    r_lhue   <= r_hue;
                    if (r_shade == SW'(SHADES_PER_HUE - 1)) begin
                        r_shade <= '0;
                        r_hue   <= (r_hue == HUE_W'(HUE_COUNT - 1)) ? '0 : r_hue + 1'b1;
                    end else begin
                        r_shade <= r_shade + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_color  <= w_esc ? w_color : '0;
            r_inside <= !w_esc;
            r_index  <= w_esc ? r_cnt - 1'b1 : i_cfg.max_iters;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pixel_color  = r_color;
    assign o_inside_set   = r_inside;
    assign o_escape_index = r_index;

endmodule

// File: hw/rtl/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
// Usage: present a pixel coordinate on i_pixel_x/i_pixel_y with i_pixel_valid;
// it transfers when o_pixel_ready is also high. One result per pixel leaves on
// o_result_valid/i_result_ready with the colour, the inside flag and the
// escape index. Results come out in the order the pixels went in.
// The front end registers the pixel-by-step products, forms c from them and
// hands it to a two-entry queue; the iteration engine runs each z step as a
// multiply state (ST_MUL) and an add/saturate/compare state (ST_ADD) through
// three 32x32 multipliers. While the engine works, the front end and queue
// keep accepting pixels until they fill. If the receiver stalls, the result
// register holds, the engine waits with its finished pixel, and back-pressure
// reaches the input. Reset is synchronous: it empties all stages and loads
// the default view (-2.5..2.5 square, step 5/1024) and a limit of 500
// iterations. Configuration is written over the APB port. The user must
// write it only while no pixel is in flight; the block does not enforce it.
module mandelbrot_escape_pixel import mep_pkg::*; #(
    parameter int SHADES_PER_HUE = 8,
    parameter int COORD_BITS     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pixel_valid,
    output logic              o_pixel_ready,
    input  logic [PIX_W-1:0]  i_pixel_x,
    input  logic [PIX_W-1:0]  i_pixel_y,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    output logic [23:0]       o_pixel_color,
    output logic              o_inside_set,
    output logic [ITER_W-1:0] o_escape_index,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg r_cfg;
    logic w_fq_valid;
    logic w_fq_ready;
    t_cpt w_fq_c;
    logic w_qi_valid;
    logic w_qi_ready;
    t_cpt w_qi_c;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_min  <= 32'shD800_0000;
            r_cfg.real_step <= 31'h0014_0000;
            r_cfg.imag_top  <= 32'sh2800_0000;
            r_cfg.imag_step <= 31'h0014_0000;
            r_cfg.max_iters <= 16'd500;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_REAL_MIN:  r_cfg.real_min  <= pwdata;
                REG_REAL_STEP: r_cfg.real_step <= pwdata[30:0];
                REG_IMAG_TOP:  r_cfg.imag_top  <= pwdata;
                REG_IMAG_STEP: r_cfg.imag_step <= pwdata[30:0];
                REG_MAX_ITERS: r_cfg.max_iters <= pwdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_REAL_MIN:  prdata = r_cfg.real_min;
            REG_REAL_STEP: prdata = {1'b0, r_cfg.real_step};
            REG_IMAG_TOP:  prdata = r_cfg.imag_top;
            REG_IMAG_STEP: prdata = {1'b0, r_cfg.imag_step};
            REG_MAX_ITERS: prdata = {{(32-ITER_W){1'b0}}, r_cfg.max_iters};
            default:       prdata = '0;
        endcase
    end

    mep_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_pixel_valid),
        .o_ready   (o_pixel_ready),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_valid   (w_fq_valid),
        .i_ready   (w_fq_ready),
        .o_c       (w_fq_c)
    );

    mep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_c     (w_fq_c),
        .o_valid (w_qi_valid),
        .i_ready (w_qi_ready),
        .o_c     (w_qi_c)
    );

    mep_iter #(
        .SHADES_PER_HUE(SHADES_PER_HUE)
    ) u_iter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_qi_valid),
        .o_ready        (w_qi_ready),
        .i_c            (w_qi_c),
        .o_valid        (o_result_valid),
        .i_ready        (i_result_ready),
        .o_pixel_color  (o_pixel_color),
        .o_inside_set   (o_inside_set),
        .o_escape_index (o_escape_index)
    );

endmodule

// File: hw/rtl/mep_check.sv
// Port-level checker for the escape-time pixel block, bound to the top level.
module mep_check import mep_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_result_valid,
    input logic              i_result_ready,
    input logic [23:0]       o_pixel_color,
    input logic              o_inside_set,
    input logic [ITER_W-1:0] o_escape_index
);

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    // a stalled result holds until its transfer
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=>
            o_result_valid && $stable(o_pixel_color) && $stable(o_inside_set)
            && $stable(o_escape_index))
        else $error("stalled result changed");

    // points inside the set are black
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_inside_set |-> o_pixel_color == 24'h000000)
        else $error("inside pixel not black");

    // every palette shade has at least one full byte, so escapes are never black
    a_escape_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_inside_set |-> o_pixel_color != 24'h000000)
        else $error("escaped pixel is black");

endmodule

bind mandelbrot_escape_pixel mep_check u_check (.*);
